// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define MVW_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define MVW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/mvw_pkg.sv -----
// Package with the payload types and constants of the moving variance window unit.
`timescale 1ns / 1ps

package mvw_pkg;

   // Fixed field widths.
   localparam int SAMPLE_BITS = 16;
   localparam int LEN_BITS    = 9;
   localparam int VAR_BITS    = 31;

   // Default ring depth and window length after reset.
   localparam int MAX_WINDOW_DEFAULT = 256;
   localparam int LEN_RESET          = 16;

   // Largest variance the arithmetic can produce: (2^(SAMPLE_BITS-1))^2.
   localparam logic [VAR_BITS-1:0] VAR_MAX = VAR_BITS'(1) << (2 * SAMPLE_BITS - 2);

   // Item operation codes.
   typedef enum logic {
      OP_ADD   = 1'b0,
      OP_CLEAR = 1'b1
   } opcode_type;

   // Input item.
   typedef struct packed {
      opcode_type                    opcode;
      logic signed [SAMPLE_BITS-1:0] sample;
   } req_payload_type;

   // Result item.
   typedef struct packed {
      logic [VAR_BITS-1:0] variance;
      logic                window_full;
   } rsp_payload_type;

endpackage

// ----- sv/mvw_ring.sv -----
// Sample ring memory: one write port and one registered read port.
`timescale 1ns / 1ps

module mvw_ring #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8,
   parameter int DATA_W = 16
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port; the read data is registered.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/mvw_div.sv -----
// Restoring divider that retires one quotient bit per cycle.
`timescale 1ns / 1ps

module mvw_div #(
   parameter int DIVIDEND_W = 40,
   parameter int DIVISOR_W  = 9
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  busy,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [DIVIDEND_W-1:0] quot_ff, quot_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  divisor_ff, divisor_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W+1:0]  diff;

   // One step: shift in the next dividend bit and subtract when it fits.
   always_comb begin
      trial      = {rem_ff, quot_ff[DIVIDEND_W-1]};
      diff       = {1'b0, trial} - {2'b00, divisor_ff};
      busy_in    = busy_ff;
      count_in   = count_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         count_in   = CNT_W'(DIVIDEND_W);
         quot_in    = dividend;
         rem_in     = '0;
         divisor_in = divisor;
      end else if (busy_ff) begin
         quot_in  = {quot_ff[DIVIDEND_W-2:0], ~diff[DIVISOR_W+1]};
         rem_in   = diff[DIVISOR_W+1] ? trial[DIVISOR_W-1:0] : diff[DIVISOR_W-1:0];
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign busy     = busy_ff;
   assign quotient = quot_ff;

endmodule

// ----- sv/moving_variance_window_unit.sv -----
// Top level of the moving variance window unit.
`timescale 1ns / 1ps
//
// Usage:
// Input items arrive on the req_ channel (valid/ready). An add item pushes a
// signed sample into a ring of the last window_length samples; a clear item
// empties the window. Every item gives exactly one result on the rsp_ channel:
// the integer variance sumsq/n - (sum/n)^2 (clamped at zero) and a full flag.
// csr_wr_en writes window_length (0 acts as 1, values above MAX_WINDOW act as
// MAX_WINDOW) and empties the window; write it only while the block is idle.
// The input is held off in a cycle with a write.
// Sequence: an add item passes through the read, update, start, divide, square,
// subtract and emit states; the divide state waits for both bit-serial
// dividers, the longer of which divides the sum of squares by the fill count.
// A clear item goes from idle straight to the emit state. The next item is
// accepted only in idle, so one item is processed at a time.
// Output: the result sits in an output register; while the receiver stalls,
// the next item is still accepted and computed, and waits for that register.
// Reset: synchronous; the window is emptied, window_length returns to 16 and
// the output register is emptied. The ring needs no clearing pass.
module moving_variance_window_unit
   import mvw_pkg::*;
#(
   parameter int MAX_WINDOW = MAX_WINDOW_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  req_payload_type     req_payload,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_payload_type     rsp_payload,
   input  logic                csr_wr_en,
   input  logic [LEN_BITS-1:0] csr_wr_data
);

   localparam int CNT_W    = $clog2(MAX_WINDOW + 1);
   localparam int ADDR_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int SUM_W    = SAMPLE_BITS + CNT_W;
   localparam int SUM_SQ_W = 2 * SAMPLE_BITS + CNT_W - 1;
   localparam int PROD_W   = 2 * SAMPLE_BITS;
   localparam int LEN_INIT = (LEN_RESET > MAX_WINDOW) ? MAX_WINDOW : LEN_RESET;

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_READ     = 8'b0000_0010,
      ST_UPDATE   = 8'b0000_0100,
      ST_START    = 8'b0000_1000,
      ST_DIVIDE   = 8'b0001_0000,
      ST_SQUARE   = 8'b0010_0000,
      ST_SUBTRACT = 8'b0100_0000,
      ST_EMIT     = 8'b1000_0000
   } state_type;

   state_type                     state_ff, state_in;
   logic [CNT_W-1:0]              len_ff, len_in;
   logic [ADDR_W-1:0]             write_slot_ff, write_slot_in;
   logic [CNT_W-1:0]              fill_ff, fill_in;
   logic signed [SUM_W-1:0]       total_ff, total_in;
   logic [SUM_SQ_W-1:0]           sum_sq_ff, sum_sq_in;
   logic [ADDR_W-1:0]             slot_ff, slot_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic                          full_ff, full_in;
   logic signed [SAMPLE_BITS-1:0] oldest_ff, oldest_in;
   logic [PROD_W-1:0]             old_sq_ff, old_sq_in;
   logic [PROD_W-1:0]             new_sq_ff, new_sq_in;
   logic [PROD_W-1:0]             mean_sq_ff, mean_sq_in;
   rsp_payload_type               result_ff, result_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   rsp_payload_type               rsp_payload_ff, rsp_payload_in;

   logic                          req_xfer;
   logic                          rsp_free;
   logic [CNT_W-1:0]              len_wr;
   logic [ADDR_W-1:0]             slot_pick;
   logic [CNT_W-1:0]              slot_inc;
   logic [SUM_W-1:0]              total_mag;
   logic [SAMPLE_BITS-1:0]        ring_rd;
   logic                          div_start;
   logic                          div_sq_busy;
   logic                          div_sum_busy;
   logic [SUM_SQ_W-1:0]           quot_sq;
   logic [SUM_W-1:0]              quot_sum;
   logic [SAMPLE_BITS-1:0]        mean_mag;
   logic [PROD_W:0]               var_diff;

   // A register write takes the idle cycle, so no item is taken beside it.
   assign req_ready = (state_ff == ST_IDLE) && !csr_wr_en;
   assign req_xfer  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign div_start = (state_ff == ST_START);
   assign mean_mag  = quot_sum[SAMPLE_BITS-1:0];

   // Effective window length for a register write.
   always_comb begin
      if (csr_wr_data == '0) begin
         len_wr = CNT_W'(1);
      end else if (32'(csr_wr_data) > 32'(MAX_WINDOW)) begin
         len_wr = CNT_W'(MAX_WINDOW);
      end else begin
         len_wr = CNT_W'(csr_wr_data);
      end
   end

   // Ring slot for the incoming sample and the slot after it.
   assign slot_pick = (CNT_W'(write_slot_ff) >= len_ff) ? '0 : write_slot_ff;
   assign slot_inc  = CNT_W'(slot_ff) + CNT_W'(1);

   // Magnitude of the running sum; the mean is only used squared.
   assign total_mag = total_ff[SUM_W-1] ? SUM_W'(-total_ff) : SUM_W'(total_ff);

   // Variance before clamping.
   assign var_diff = {1'b0, quot_sq[PROD_W-1:0]} - {1'b0, mean_sq_ff};

   // Sequencer: read the oldest sample, update the sums, divide, square, emit.
   always_comb begin
      state_in      = state_ff;
      len_in        = len_ff;
      write_slot_in = write_slot_ff;
      fill_in       = fill_ff;
      total_in      = total_ff;
      sum_sq_in     = sum_sq_ff;
      slot_in       = slot_ff;
      sample_in     = sample_ff;
      full_in       = full_ff;
      oldest_in     = oldest_ff;
      old_sq_in     = old_sq_ff;
      new_sq_in     = new_sq_ff;
      mean_sq_in    = mean_sq_ff;
      result_in     = result_ff;
      case (state_ff)
         ST_IDLE: begin
            if (csr_wr_en) begin
               len_in        = len_wr;
               write_slot_in = '0;
               fill_in       = '0;
               total_in      = '0;
               sum_sq_in     = '0;
            end else if (req_xfer) begin
               if (req_payload.opcode == OP_CLEAR) begin
                  write_slot_in = '0;
                  fill_in       = '0;
                  total_in      = '0;
                  sum_sq_in     = '0;
                  result_in     = '0;
                  state_in      = ST_EMIT;
               end else begin
                  slot_in   = slot_pick;
                  sample_in = req_payload.sample;
                  full_in   = (fill_ff >= len_ff);
                  state_in  = ST_READ;
               end
            end
         end
         ST_READ: begin
            oldest_in = full_ff ? signed'(ring_rd) : '0;
            old_sq_in = PROD_W'(oldest_in) * PROD_W'(oldest_in);
            new_sq_in = PROD_W'(sample_ff) * PROD_W'(sample_ff);
            state_in  = ST_UPDATE;
         end
         ST_UPDATE: begin
            total_in      = total_ff - SUM_W'(oldest_ff) + SUM_W'(sample_ff);
            sum_sq_in     = sum_sq_ff - SUM_SQ_W'(old_sq_ff) + SUM_SQ_W'(new_sq_ff);
            fill_in       = full_ff ? len_ff : fill_ff + CNT_W'(1);
            write_slot_in = (slot_inc >= len_ff) ? '0 : ADDR_W'(slot_inc);
            state_in      = ST_START;
         end
         ST_START: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (!div_sq_busy && !div_sum_busy) begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            mean_sq_in = PROD_W'(mean_mag) * PROD_W'(mean_mag);
            state_in   = ST_SUBTRACT;
         end
         ST_SUBTRACT: begin
            result_in.variance    = var_diff[PROD_W] ? '0 : var_diff[VAR_BITS-1:0];
            result_in.window_full = (fill_ff >= len_ff);
            state_in              = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register: loads the finished result once the previous one is taken.
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == ST_EMIT && rsp_free) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = result_ff;
      end
   end

   // Control state and window state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         len_ff        <= CNT_W'(LEN_INIT);
         write_slot_ff <= '0;
         fill_ff       <= '0;
         total_ff      <= '0;
         sum_sq_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         len_ff        <= len_in;
         write_slot_ff <= write_slot_in;
         fill_ff       <= fill_in;
         total_ff      <= total_in;
         sum_sq_ff     <= sum_sq_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      slot_ff        <= slot_in;
      sample_ff      <= sample_in;
      full_ff        <= full_in;
      oldest_ff      <= oldest_in;
      old_sq_ff      <= old_sq_in;
      new_sq_ff      <= new_sq_in;
      mean_sq_ff     <= mean_sq_in;
      result_ff      <= result_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Sample ring: read at acceptance, write back the new sample in the read state that follows.
   mvw_ring #(
      .DEPTH  (MAX_WINDOW),
      .ADDR_W (ADDR_W),
      .DATA_W (SAMPLE_BITS)
   ) u_ring (
      .clock   (clock),
      .rd_en   (req_xfer),
      .rd_addr (slot_pick),
      .rd_data (ring_rd),
      .wr_en   (state_ff == ST_READ),
      .wr_addr (slot_ff),
      .wr_data (sample_ff)
   );

   // Sum of squares divided by the fill count.
   mvw_div #(
      .DIVIDEND_W (SUM_SQ_W),
      .DIVISOR_W  (CNT_W)
   ) u_div_sq (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_sq_ff),
      .divisor  (fill_ff),
      .busy     (div_sq_busy),
      .quotient (quot_sq)
   );

   // Magnitude of the sum divided by the fill count.
   mvw_div #(
      .DIVIDEND_W (SUM_W),
      .DIVISOR_W  (CNT_W)
   ) u_div_sum (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (total_mag),
      .divisor  (fill_ff),
      .busy     (div_sum_busy),
      .quotient (quot_sum)
   );

endmodule

// ----- sv/mvw_checker.sv -----
// Port-level checker for the moving variance window unit, with its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mvw_checker
   import mvw_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input req_payload_type req_payload,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_payload
);

   logic       in_xfer;
   logic       out_xfer;
   logic [1:0] pending_ff, pending_in;

   assign in_xfer  = req_valid && req_ready;
   assign out_xfer = rsp_valid && rsp_ready;

   // Items accepted whose result has not yet been transferred.
   always_comb begin
      pending_in = pending_ff;
      if (in_xfer && !out_xfer) begin
         pending_in = pending_ff + 2'd1;
      end else if (!in_xfer && out_xfer) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // A stalled result holds its value.
   `MVW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_payload), "result changed while stalled")

   // No result transfer without an accepted item behind it.
   `MVW_ASSERT_SAME(a_no_extra_rsp, clock, reset, out_xfer, pending_ff != 2'd0,
      "result without an item")

   // With one result waiting and one item in work, no further item is taken.
   `MVW_ASSERT_SAME(a_two_in_flight, clock, reset, pending_ff == 2'd2, !req_ready,
      "third item accepted")

   // The variance never exceeds the square of the largest sample magnitude.
   `MVW_ASSERT_SAME(a_var_bound, clock, reset, rsp_valid,
      rsp_payload.variance <= VAR_MAX, "variance out of range")

endmodule

bind moving_variance_window_unit mvw_checker u_checker (.*);
